// ===== rtl/lbpc_pkg.sv =====
// Package with the shared types and constants of the LED blink and pulse controller.
package lbpc_pkg;

   // Widths of the payload fields and of the configuration port.
   localparam int CHANNEL_WIDTH   = 2;
   localparam int COMMAND_WIDTH   = 2;
   localparam int MASK_WIDTH      = 3;
   localparam int COUNT_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLINK_HALF_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSE_LENGTH      = 1'd1;

   // Register values after reset.
   localparam logic [COUNT_WIDTH-1:0] BLINK_HALF_PERIOD_RESET = 16'd25;
   localparam logic [COUNT_WIDTH-1:0] PULSE_LENGTH_RESET      = 16'd50;

   // Request kinds.
   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_COMMAND = 1'b1;

   // Command codes.
   localparam logic [COMMAND_WIDTH-1:0] CMD_STOP  = 2'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_BLINK = 2'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_PULSE = 2'd2;

   // Channel mode, one-hot.
   typedef enum logic [3:0] {
      MODE_OFF       = 4'b0001,
      MODE_BLINK_ON  = 4'b0010,
      MODE_BLINK_OFF = 4'b0100,
      MODE_PULSE     = 4'b1000
   } mode_type;

endpackage

// ===== rtl/lbpc_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
interface lbpc_req_if;
   import lbpc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [CHANNEL_WIDTH-1:0] channel;
   logic [COMMAND_WIDTH-1:0] command;

   modport source (output valid, output req_type, output channel, output command,
                   input ready);
   modport sink   (input valid, input req_type, input channel, input command,
                   output ready);
endinterface

interface lbpc_rsp_if;
   import lbpc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MASK_WIDTH-1:0] led_on_mask;
   logic [MASK_WIDTH-1:0] active_mask;

   modport source (output valid, output led_on_mask, output active_mask, input ready);
   modport sink   (input valid, input led_on_mask, input active_mask, output ready);
endinterface

// ===== rtl/led_blink_pulse_controller.sv =====
// Top level of the LED blink and pulse controller.
//
// Channels: req_bus carries one beat per item. A command beat (req_type high)
// latches a pending stop, blink or pulse event for one channel, replacing any
// earlier one; a tick beat (req_type low) steps every channel once. rsp_bus
// returns one beat per request with the LED levels and the active channels
// after that request; mask bits at index CHANNELS and above read as zero.
// Configuration: csr_write_en writes blink_half_period (index 0) or
// pulse_length (index 1) from csr_write_data on the same clock edge.
// Latency: the response beat is valid on the cycle after the request is
// accepted. Throughput: one request per cycle while no response is stalled, set by
// the single update of the channel state registers and the one response register.
// Reset: all channels go to off with no event pending, and the two
// registers return to 25 and 50 ticks. No response is held.
// Stall: while a response waits and rsp_bus.ready is low, req_bus.ready is
// low; as soon as the response is taken, a new request is accepted in the
// same cycle.
module led_blink_pulse_controller #(
   parameter int CHANNELS = 3
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_en,
   input  logic [lbpc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [lbpc_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   lbpc_req_if.sink                                 req_bus,
   lbpc_rsp_if.source                               rsp_bus
);
   import lbpc_pkg::*;

   logic [COUNT_WIDTH-1:0]   blink_half_period_ff;
   logic [COUNT_WIDTH-1:0]   pulse_length_ff;

   mode_type                 mode_ff      [CHANNELS];
   mode_type                 mode_in      [CHANNELS];
   logic [COUNT_WIDTH-1:0]   countdown_ff [CHANNELS];
   logic [COUNT_WIDTH-1:0]   countdown_in [CHANNELS];
   logic                     pending_ff   [CHANNELS];
   logic                     pending_in   [CHANNELS];
   logic [COMMAND_WIDTH-1:0] pend_cmd_ff  [CHANNELS];
   logic [COMMAND_WIDTH-1:0] pend_cmd_in  [CHANNELS];
   logic                     led_ff       [CHANNELS];
   logic                     led_in       [CHANNELS];

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [MASK_WIDTH-1:0]    led_mask_ff;
   logic [MASK_WIDTH-1:0]    led_mask_in;
   logic [MASK_WIDTH-1:0]    act_mask_ff;
   logic [MASK_WIDTH-1:0]    act_mask_in;

   logic                     req_accept;
   logic                     cmd_valid;

   // A request is taken whenever the response register is empty or being drained.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (req_bus.command == CMD_STOP) || (req_bus.command == CMD_BLINK) ||
                          (req_bus.command == CMD_PULSE);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_half_period_ff <= BLINK_HALF_PERIOD_RESET;
         pulse_length_ff      <= PULSE_LENGTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BLINK_HALF_PERIOD: blink_half_period_ff <= csr_write_data;
            CSR_PULSE_LENGTH:      pulse_length_ff      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Next state of every channel for the beat on the request channel.
   always_comb begin
      logic [COUNT_WIDTH-1:0] dec;
      logic                   hit;
      for (int c = 0; c < CHANNELS; c++) begin
         mode_in[c]      = mode_ff[c];
         countdown_in[c] = countdown_ff[c];
         pending_in[c]   = pending_ff[c];
         pend_cmd_in[c]  = pend_cmd_ff[c];
         led_in[c]       = led_ff[c];
         dec             = countdown_ff[c] - 16'd1;
         hit             = ({30'd0, req_bus.channel} == 32'(c));

         if (req_bus.req_type == REQ_COMMAND) begin
            // A command only records the event; a later one replaces it.
            if (hit && cmd_valid) begin
               pending_in[c]  = 1'b1;
               pend_cmd_in[c] = req_bus.command;
            end
         end else begin
            case (mode_ff[c])
               MODE_OFF: begin
                  if (pending_ff[c] && pend_cmd_ff[c] == CMD_BLINK) begin
                     pending_in[c]   = 1'b0;
                     countdown_in[c] = blink_half_period_ff;
                     led_in[c]       = 1'b1;
                     mode_in[c]      = MODE_BLINK_ON;
                  end else if (pending_ff[c] && pend_cmd_ff[c] == CMD_PULSE) begin
                     pending_in[c]   = 1'b0;
                     countdown_in[c] = pulse_length_ff;
                     led_in[c]       = 1'b1;
                     mode_in[c]      = MODE_PULSE;
                  end
               end
               MODE_BLINK_ON: begin
                  // A stop ends the blink at once and leaves the counter as it is.
                  if (pending_ff[c] && pend_cmd_ff[c] == CMD_STOP) begin
                     pending_in[c] = 1'b0;
                     led_in[c]     = 1'b0;
                     mode_in[c]    = MODE_OFF;
                  end else if (dec == '0) begin
                     countdown_in[c] = blink_half_period_ff;
                     led_in[c]       = 1'b0;
                     mode_in[c]      = MODE_BLINK_OFF;
                  end else begin
                     countdown_in[c] = dec;
                  end
               end
               MODE_BLINK_OFF: begin
                  if (dec == '0) begin
                     countdown_in[c] = blink_half_period_ff;
                     led_in[c]       = 1'b1;
                     mode_in[c]      = MODE_BLINK_ON;
                  end else begin
                     countdown_in[c] = dec;
                  end
               end
               MODE_PULSE: begin
                  if (dec == '0) begin
                     countdown_in[c] = pulse_length_ff;
                     led_in[c]       = 1'b0;
                     mode_in[c]      = MODE_OFF;
                  end else begin
                     countdown_in[c] = dec;
                  end
               end
               default: begin
                  led_in[c]  = 1'b0;
                  mode_in[c] = MODE_OFF;
               end
            endcase
         end
      end
   end

   // Channel state registers, updated on every accepted request beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            mode_ff[c]      <= MODE_OFF;
            countdown_ff[c] <= '0;
            pending_ff[c]   <= 1'b0;
            pend_cmd_ff[c]  <= CMD_STOP;
            led_ff[c]       <= 1'b0;
         end
      end else if (req_accept) begin
         for (int c = 0; c < CHANNELS; c++) begin
            mode_ff[c]      <= mode_in[c];
            countdown_ff[c] <= countdown_in[c];
            pending_ff[c]   <= pending_in[c];
            pend_cmd_ff[c]  <= pend_cmd_in[c];
            led_ff[c]       <= led_in[c];
         end
      end
   end

   // Response masks from the next state; channels past the last one read as zero.
   always_comb begin
      for (int b = 0; b < MASK_WIDTH; b++) begin
         if (b < CHANNELS) begin
            led_mask_in[b] = led_in[b];
            act_mask_in[b] = (mode_in[b] != MODE_OFF);
         end else begin
            led_mask_in[b] = 1'b0;
            act_mask_in[b] = 1'b0;
         end
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_bus.ready);

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         led_mask_ff <= led_mask_in;
         act_mask_ff <= act_mask_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.led_on_mask = led_mask_ff;
   assign rsp_bus.active_mask = act_mask_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the LED blink and pulse controller: random and directed beats, checked per field.
module tb;
   import lbpc_pkg::*;

   localparam int NUM_CHANNELS = 3;
   localparam int STALL_LIMIT  = 4000;

   typedef struct packed {
      logic                     req_type;
      logic [CHANNEL_WIDTH-1:0] channel;
      logic [COMMAND_WIDTH-1:0] command;
   } lamp_request_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0] led_on_mask;
      logic [MASK_WIDTH-1:0] active_mask;
   } lamp_status_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   lbpc_req_if req_if ();
   lbpc_rsp_if rsp_if ();

   led_blink_pulse_controller #(
      .CHANNELS(NUM_CHANNELS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data),
      .req_bus       (req_if),
      .rsp_bus       (rsp_if)
   );

   // Stimulus and scoreboard storage.
   lamp_request_type pending_requests[$];
   lamp_status_type  expected_status[$];
   int            fail_count    = 0;
   int            stall_cycles  = 0;
   int unsigned   tx_idle_pct   = 0;
   int unsigned   rx_idle_pct   = 0;

   // Predicted controller state, one entry per channel.
   mode_type                 lamp_mode  [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]   lamp_count [NUM_CHANNELS];
   logic                     lamp_event [NUM_CHANNELS];
   logic [COMMAND_WIDTH-1:0] lamp_cmd   [NUM_CHANNELS];
   logic                     lamp_lit   [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]   model_half_period = BLINK_HALF_PERIOD_RESET;
   logic [COUNT_WIDTH-1:0]   model_pulse_len   = PULSE_LENGTH_RESET;

   initial begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         lamp_mode[c]  = MODE_OFF;
         lamp_count[c] = '0;
         lamp_event[c] = 1'b0;
         lamp_cmd[c]   = CMD_STOP;
         lamp_lit[c]   = 1'b0;
      end
   end

   // Clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Applies one accepted beat to the predicted state and returns the status it leaves.
   function automatic lamp_status_type apply_request(input lamp_request_type r);
      lamp_status_type s;
      s = '0;
      if (r.req_type == REQ_COMMAND) begin
         if (r.channel < NUM_CHANNELS && r.command <= CMD_PULSE) begin
            lamp_event[r.channel] = 1'b1;
            lamp_cmd[r.channel]   = r.command;
         end
      end else begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            case (lamp_mode[c])
               MODE_OFF: begin
                  if (lamp_event[c] && lamp_cmd[c] == CMD_BLINK) begin
                     lamp_event[c] = 1'b0;
                     lamp_count[c] = model_half_period;
                     lamp_lit[c]   = 1'b1;
                     lamp_mode[c]  = MODE_BLINK_ON;
                  end else if (lamp_event[c] && lamp_cmd[c] == CMD_PULSE) begin
                     lamp_event[c] = 1'b0;
                     lamp_count[c] = model_pulse_len;
                     lamp_lit[c]   = 1'b1;
                     lamp_mode[c]  = MODE_PULSE;
                  end
               end
               MODE_BLINK_ON: begin
                  // A stop is honored here only, and skips the decrement.
                  if (lamp_event[c] && lamp_cmd[c] == CMD_STOP) begin
                     lamp_event[c] = 1'b0;
                     lamp_lit[c]   = 1'b0;
                     lamp_mode[c]  = MODE_OFF;
                  end else begin
                     lamp_count[c] = lamp_count[c] - 1'b1;
                     if (lamp_count[c] == '0) begin
                        lamp_count[c] = model_half_period;
                        lamp_lit[c]   = 1'b0;
                        lamp_mode[c]  = MODE_BLINK_OFF;
                     end
                  end
               end
               MODE_BLINK_OFF: begin
                  lamp_count[c] = lamp_count[c] - 1'b1;
                  if (lamp_count[c] == '0) begin
                     lamp_count[c] = model_half_period;
                     lamp_lit[c]   = 1'b1;
                     lamp_mode[c]  = MODE_BLINK_ON;
                  end
               end
               default: begin
                  lamp_count[c] = lamp_count[c] - 1'b1;
                  if (lamp_count[c] == '0) begin
                     lamp_count[c] = model_pulse_len;
                     lamp_lit[c]   = 1'b0;
                     lamp_mode[c]  = MODE_OFF;
                  end
               end
            endcase
         end
      end
      for (int c = 0; c < NUM_CHANNELS && c < MASK_WIDTH; c++) begin
         s.led_on_mask[c] = lamp_lit[c];
         s.active_mask[c] = (lamp_mode[c] != MODE_OFF);
      end
      return s;
   endfunction

   // Request driver: predicts each accepted beat and presents the next one.
   always @(posedge clock) begin
      lamp_request_type sent;
      lamp_request_type next_req;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            sent = {req_if.req_type, req_if.channel, req_if.command};
            expected_status.push_back(apply_request(sent));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_if.valid    <= 1'b1;
               req_if.req_type <= next_req.req_type;
               req_if.channel  <= next_req.channel;
               req_if.command  <= next_req.command;
            end else begin
               req_if.valid    <= 1'b0;
               req_if.req_type <= 1'($urandom_range(1));
               req_if.channel  <= 2'($urandom_range(3));
               req_if.command  <= 2'($urandom_range(3));
            end
         end
      end
   end

   // Response side: random back-pressure.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Response monitor: each beat is compared with the oldest prediction.
   always @(posedge clock) begin
      lamp_status_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_status.size() == 0) begin
            $error("response beat with no request outstanding: led_on_mask %0h active_mask %0h",
                   rsp_if.led_on_mask, rsp_if.active_mask);
            fail_count++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_if.led_on_mask !== want.led_on_mask) begin
               $error("led_on_mask: expected %0h, got %0h", want.led_on_mask, rsp_if.led_on_mask);
               fail_count++;
            end
            if (rsp_if.active_mask !== want.active_mask) begin
               $error("active_mask: expected %0h, got %0h", want.active_mask, rsp_if.active_mask);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic add_request(input logic rt, input logic [CHANNEL_WIDTH-1:0] ch,
                              input logic [COMMAND_WIDTH-1:0] cmd);
      pending_requests.push_back('{rt, ch, cmd});
   endtask

   // A mix of ticks and commands, mostly valid codes to real channels; some carry any channel or code.
   task automatic add_random_requests(input int count);
      lamp_request_type r;
      repeat (count) begin
         r.req_type = ($urandom_range(99) < 55) ? REQ_TICK : REQ_COMMAND;
         if ($urandom_range(9) == 0) begin
            r.channel = 2'($urandom_range(3));
            r.command = 2'($urandom_range(3));
         end else begin
            r.channel = 2'($urandom_range(NUM_CHANNELS - 1));
            r.command = 2'($urandom_range(CMD_PULSE));
         end
         pending_requests.push_back(r);
      end
   endtask

   // Waits until every queued beat has been sent and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_if.valid || expected_status.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      case (idx)
         CSR_BLINK_HALF_PERIOD: model_half_period = data;
         CSR_PULSE_LENGTH:      model_pulse_len   = data;
         default: ;
      endcase
   endtask

   task automatic set_periods(input logic [CSR_DATA_WIDTH-1:0] half_period,
                              input logic [CSR_DATA_WIDTH-1:0] pulse_len);
      write_reg(CSR_BLINK_HALF_PERIOD, half_period);
      write_reg(CSR_PULSE_LENGTH, pulse_len);
   endtask

   initial begin
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_write_data  = '0;
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_TICK;
      req_if.channel  = '0;
      req_if.command  = CMD_STOP;
      rsp_if.ready    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset periods.
      tx_idle_pct = 19;
      rx_idle_pct = 79;
      add_request(REQ_TICK, 2'd3, 2'd3);
      // A stop while off stays pending and does nothing.
      add_request(REQ_COMMAND, 2'd0, CMD_STOP);
      add_request(REQ_TICK, 2'd0, CMD_STOP);
      add_request(REQ_COMMAND, 2'd0, CMD_BLINK);
      add_request(REQ_TICK, 2'd1, CMD_PULSE);
      // A later command replaces the pending one.
      add_request(REQ_COMMAND, 2'd1, CMD_STOP);
      add_request(REQ_COMMAND, 2'd1, CMD_PULSE);
      add_request(REQ_TICK, 2'd0, CMD_BLINK);
      add_request(REQ_COMMAND, 2'd2, CMD_PULSE);
      add_request(REQ_COMMAND, 2'd2, CMD_BLINK);
      add_request(REQ_TICK, 2'd3, CMD_STOP);
      // Unknown code and a channel out of range are both dropped.
      add_request(REQ_COMMAND, 2'd2, 2'd3);
      add_request(REQ_COMMAND, 2'd3, CMD_BLINK);
      add_request(REQ_TICK, 2'd2, 2'd3);
      // A stop during a pulse is not honored and stays pending.
      add_request(REQ_COMMAND, 2'd1, CMD_STOP);
      add_request(REQ_TICK, 2'd1, CMD_STOP);
      add_request(REQ_COMMAND, 2'd0, CMD_STOP);
      add_request(REQ_TICK, 2'd0, CMD_STOP);
      add_request(REQ_COMMAND, 2'd2, CMD_STOP);
      add_request(REQ_TICK, 2'd2, CMD_STOP);
      add_request(REQ_TICK, 2'd0, CMD_STOP);
      add_random_requests(300);
      wait_drained();

      // Shortest periods.
      set_periods(16'd1, 16'd1);
      add_random_requests(250);
      wait_drained();

      // Zero periods: the decrement wraps, so phases run very long.
      tx_idle_pct = 79;
      rx_idle_pct = 19;
      set_periods(16'd0, 16'd0);
      add_random_requests(150);
      wait_drained();

      set_periods(16'($urandom_range(2, 6)), 16'($urandom_range(2, 6)));
      add_random_requests(250);
      wait_drained();

      // Largest period values, then a mix, with no idling.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_periods(16'hFFFF, 16'hFFFF);
      add_random_requests(100);
      wait_drained();

      set_periods(16'($urandom_range(2, 9)), 16'd1);
      add_random_requests(100);
      wait_drained();

      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
